// File: sv/tslb_pkg.sv
// shared constants, types and helpers of the tcp session load balancer
package tslb_pkg;

    localparam int unsigned SESSION_SLOTS  = 40000;
    localparam int unsigned SLOT_PORT_BASE = 10000;
    localparam int unsigned SLOT_W         = $clog2(SESSION_SLOTS);

    // slot count = odd part times a power of two; the remainder by the odd part
    // comes from a reciprocal multiply, exact for every 26-bit dividend
    localparam int unsigned SLOT_LOW_W  = 6;
    localparam int unsigned SLOT_ODD    = SESSION_SLOTS >> SLOT_LOW_W;
    localparam int unsigned HI_W        = 32 - SLOT_LOW_W;
    localparam int unsigned RECIP_SHIFT = 36;
    localparam int unsigned RECIP_W     = 27;
    localparam int unsigned QUO_W       = HI_W + RECIP_W - RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] SLOT_RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(SLOT_ODD) - 64'd1) / 64'(SLOT_ODD));

    localparam logic [31:0] XP2 = 32'd2246822519;
    localparam logic [31:0] XP3 = 32'd3266489917;
    localparam logic [31:0] XP4 = 32'd668265263;
    localparam logic [31:0] XP5 = 32'd374761393;

    localparam logic [31:0] RST_BALANCER_IP  = 32'h0AC9_0004;
    localparam logic [47:0] RST_BALANCER_MAC = 48'hDEAD_BEEF_0004;
    localparam logic [15:0] RST_SERVICE_PORT = 16'd8000;

    // register indexes of the configuration channel
    localparam logic [2:0] CFG_BALANCER_IP  = 3'd0;
    localparam logic [2:0] CFG_BALANCER_MAC = 3'd1;
    localparam logic [2:0] CFG_SERVICE_PORT = 3'd2;
    localparam logic [2:0] CFG_SERVER0_IP   = 3'd3;
    localparam logic [2:0] CFG_SERVER0_MAC  = 3'd4;
    localparam logic [2:0] CFG_SERVER1_IP   = 3'd5;
    localparam logic [2:0] CFG_SERVER1_MAC  = 3'd6;

    typedef enum logic [1:0] {
        ACT_PASS = 2'd0,
        ACT_DROP = 2'd1,
        ACT_TX   = 2'd2
    } t_action;

    // side-closed bits
    localparam logic [1:0] SIDE_CLIENT = 2'b01;
    localparam logic [1:0] SIDE_SERVER = 2'b10;

    typedef struct packed {
        logic        valid;
        logic [31:0] cl_ip;
        logic [15:0] cl_port;
        logic [47:0] cl_mac;
        logic [31:0] sv_ip;
        logic [47:0] sv_mac;
        logic [1:0]  side_closed;
    } t_entry;

    typedef struct packed {
        logic        headers_ok;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic        syn;
        logic        fin;
        logic        ack;
        logic        rst;
    } t_header;

    typedef struct packed {
        t_action     action;
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic        removed;
    } t_result;

    function automatic logic [15:0] swap16(input logic [15:0] v);
        return {v[7:0], v[15:8]};
    endfunction

endpackage

// File: sv/tslb_hash.sv
// client hash (xxh32 over address and port) and slot index by reciprocal remainder
module tslb_hash
    import tslb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [31:0]       i_ip,
    input  logic [15:0]       i_port,
    output logic              o_done,
    output logic              o_server_sel,
    output logic [SLOT_W-1:0] o_slot
);

    typedef enum logic [3:0] {
        H_IDLE, H_M1, H_M2, H_M3, H_M4, H_M5, H_M6, H_FIN, H_QUO, H_REM, H_DONE
    } t_hstate;

    t_hstate                   r_state;
    logic [31:0]               r_p;
    logic [SLOT_W-1:0]         r_rem;
    logic [QUO_W-1:0]          r_q;
    logic [31:0]               w_h0;
    logic [HI_W-1:0]           w_hi;
    logic [HI_W+RECIP_W-1:0]   w_prod;
    logic [HI_W-1:0]           w_rem_hi;

    assign w_h0     = XP5 + 32'd8 + r_p;
    // hash = hi * 64 + lo, so hash mod slots = (hi mod odd part) * 64 + lo
    assign w_hi     = r_p[31:SLOT_LOW_W];
    assign w_prod   = (HI_W+RECIP_W)'(w_hi) * (HI_W+RECIP_W)'(SLOT_RECIP);
    assign w_rem_hi = w_hi - HI_W'(r_q * SLOT_ODD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
        end else begin
            case (r_state)
                H_IDLE: if (i_start) r_state <= H_M1;
                H_M1: begin
                    r_p     <= {i_ip[7:0], i_ip[15:8], i_ip[23:16], i_ip[31:24]} * XP3;
                    r_state <= H_M2;
                end
                H_M2: begin
                    r_p     <= {w_h0[14:0], w_h0[31:15]} * XP4;
                    r_state <= H_M3;
                end
                H_M3: begin
                    r_p     <= r_p + {16'd0, i_port} * XP3;
                    r_state <= H_M4;
                end
                H_M4: begin
                    r_p     <= {r_p[14:0], r_p[31:15]} * XP4;
                    r_state <= H_M5;
                end
                H_M5: begin
                    r_p     <= (r_p ^ (r_p >> 15)) * XP2;
                    r_state <= H_M6;
                end
                H_M6: begin
                    r_p     <= (r_p ^ (r_p >> 13)) * XP3;
                    r_state <= H_FIN;
                end
                H_FIN: begin
                    r_p     <= r_p ^ (r_p >> 16);
                    r_state <= H_QUO;
                end
                H_QUO: begin
                    r_q     <= w_prod[HI_W+RECIP_W-1:RECIP_SHIFT];
                    r_state <= H_REM;
                end
                H_REM: begin
                    r_rem   <= SLOT_W'({w_rem_hi, r_p[SLOT_LOW_W-1:0]});
                    r_state <= H_DONE;
                end
                H_DONE:  r_state <= H_IDLE;
                default: r_state <= H_IDLE;
            endcase
        end
    end

    assign o_done       = (r_state == H_DONE);
    assign o_server_sel = r_p[0];
    assign o_slot       = r_rem;

endmodule

// File: sv/tcp_session_load_balancer_top.sv
// top level of the tcp session load balancer: sequencer, session memory, registers
//
// channels: s_axis carries one parsed tcp/ipv4 header per request, m_axis one
// verdict with the rewritten addresses and ports, cfg writes one register
// (index 0..6) per request and is always ready.
// paths: a header that is passed (bad headers or no service port) or a server
// reply outside the slots goes straight to the emit step; a server reply reads
// and modifies its slot; a client request first runs the ten-step hash unit
// (xxh32 rounds, then a two-step remainder by the slot count).
// one header is in work at a time: s_axis_tready rises again once its result
// sits in the output register.
// session memory: one single-port synchronous ram, one entry per slot, read
// then modified and written back; only one header is in flight, so accesses
// to the same slot never overlap.
// reset: registers take their reset values, then a clearing pass writes every
// slot invalid, during which no header is taken (cfg works).
// stall: a result waits in the output register while m_axis_tready is low;
// the next header is then held in the emit step until the register frees.
module tcp_session_load_balancer_top
    import tslb_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // fields from bit 0: in_src_mac, in_dst_mac, in_src_ip, in_dst_ip,
    // in_src_port, in_dst_port, flag_syn, flag_fin, flag_ack, flag_rst, pad
    input  logic [199:0] s_axis_tdata,
    input  logic [0:0]   s_axis_tuser,   // headers_ok
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // fields from bit 0: out_dst_mac, out_src_mac, out_src_ip, out_dst_ip,
    // out_src_port, out_dst_port, session_removed, pad
    output logic [199:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,   // action
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [47:0]  i_cfg_data
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_HASH, S_READ, S_MODIFY, S_EMIT
    } t_state;

    t_state            r_state;
    t_header           r_in;
    t_result           r_res;
    t_result           r_out;
    logic              r_out_valid;
    logic              r_client;
    logic              r_server_sel;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] r_clr;

    logic [31:0]       r_balancer_ip;
    logic [47:0]       r_balancer_mac;
    logic [15:0]       r_service_port;
    logic [31:0]       r_server0_ip;
    logic [47:0]       r_server0_mac;
    logic [31:0]       r_server1_ip;
    logic [47:0]       r_server1_mac;

    t_entry            r_mem [SESSION_SLOTS];
    t_entry            r_rd;

    t_header           w_hdr;
    t_result           w_echo;
    logic              w_hash_done;
    logic              w_hash_sel;
    logic [SLOT_W-1:0] w_hash_slot;
    logic [15:0]       w_key;
    logic [16:0]       w_key_off;
    logic              w_key_bad;
    logic              w_out_free;

    t_entry            w_ent;
    t_result           w_mod;
    logic              w_drop;
    logic [1:0]        w_side;
    logic              w_we;
    logic [SLOT_W-1:0] w_wa;
    t_entry            w_wd;

    assign w_hdr.headers_ok = s_axis_tuser[0];
    assign w_hdr.src_mac    = s_axis_tdata[47:0];
    assign w_hdr.dst_mac    = s_axis_tdata[95:48];
    assign w_hdr.src_ip     = s_axis_tdata[127:96];
    assign w_hdr.dst_ip     = s_axis_tdata[159:128];
    assign w_hdr.sport      = s_axis_tdata[175:160];
    assign w_hdr.dport      = s_axis_tdata[191:176];
    assign w_hdr.syn        = s_axis_tdata[192];
    assign w_hdr.fin        = s_axis_tdata[193];
    assign w_hdr.ack        = s_axis_tdata[194];
    assign w_hdr.rst        = s_axis_tdata[195];

    // server replies carry the slot port byte-swapped
    assign w_key     = swap16(w_hdr.dport);
    assign w_key_off = {1'b0, w_key} - 17'(SLOT_PORT_BASE);
    assign w_key_bad = w_key_off[16] || (w_key_off >= 17'(SESSION_SLOTS));

    // echo of the header, the answer for pass and drop; a server reply whose
    // port lies outside the slots is dropped right away
    always_comb begin
        w_echo.action   = ACT_PASS;
        if (w_hdr.headers_ok && w_hdr.dport != r_service_port &&
            w_hdr.sport == r_service_port && w_key_bad)
            w_echo.action = ACT_DROP;
        w_echo.dst_mac  = w_hdr.dst_mac;
        w_echo.src_mac  = w_hdr.src_mac;
        w_echo.src_ip   = w_hdr.src_ip;
        w_echo.dst_ip   = w_hdr.dst_ip;
        w_echo.sport    = w_hdr.sport;
        w_echo.dport    = w_hdr.dport;
        w_echo.removed  = 1'b0;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // the hash reads the registered header from the cycle after the request
    tslb_hash u_hash (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (s_axis_tvalid && s_axis_tready && w_hdr.headers_ok &&
                       (w_hdr.dport == r_service_port)),
        .i_ip         (r_in.src_ip),
        .i_port       (r_in.sport),
        .o_done       (w_hash_done),
        .o_server_sel (w_hash_sel),
        .o_slot       (w_hash_slot)
    );

    // read-modify-write of the session entry
    always_comb begin
        w_ent  = r_rd;
        w_drop = 1'b0;
        w_side = r_client ? SIDE_CLIENT : SIDE_SERVER;
        w_mod  = r_res;
        if (r_client && r_in.syn) begin
            if (r_rd.valid) begin
                w_drop = 1'b1;
            end else begin
                w_ent.valid       = 1'b1;
                w_ent.cl_ip       = r_in.src_ip;
                w_ent.cl_port     = r_in.sport;
                w_ent.cl_mac      = r_in.src_mac;
                w_ent.sv_ip       = r_server_sel ? r_server1_ip  : r_server0_ip;
                w_ent.sv_mac      = r_server_sel ? r_server1_mac : r_server0_mac;
                w_ent.side_closed = 2'b00;
            end
        end else if (!r_rd.valid) begin
            w_drop = 1'b1;
        end
        if (w_drop) begin
            w_mod.action = ACT_DROP;
        end else begin
            w_mod.action = ACT_TX;
            w_mod.src_mac = r_balancer_mac;
            w_mod.src_ip  = r_balancer_ip;
            if (r_client) begin
                w_mod.dst_mac = w_ent.sv_mac;
                w_mod.dst_ip  = w_ent.sv_ip;
                w_mod.sport   = swap16(16'(r_slot) + 16'(SLOT_PORT_BASE));
            end else begin
                w_mod.dst_mac = w_ent.cl_mac;
                w_mod.dst_ip  = w_ent.cl_ip;
                w_mod.dport   = w_ent.cl_port;
            end
            // rst deletes; fin closes an open side; ack on a closed side
            // deletes once both sides are closed
            if (r_in.rst) begin
                w_ent.valid   = 1'b0;
                w_mod.removed = 1'b1;
            end else if ((w_ent.side_closed & w_side) == 2'b00) begin
                if (r_in.fin) w_ent.side_closed = w_ent.side_closed | w_side;
            end else if (r_in.ack && w_ent.side_closed == 2'b11) begin
                w_ent.valid   = 1'b0;
                w_mod.removed = 1'b1;
            end
        end
    end

    always_comb begin
        w_we = 1'b0;
        w_wa = r_slot;
        w_wd = w_ent;
        if (r_state == S_CLEAR) begin
            w_we = 1'b1;
            w_wa = r_clr;
            w_wd = '0;
        end else if (r_state == S_MODIFY && !w_drop) begin
            w_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        if (r_state == S_READ) r_rd <= r_mem[r_slot];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_balancer_ip  <= RST_BALANCER_IP;
            r_balancer_mac <= RST_BALANCER_MAC;
            r_service_port <= RST_SERVICE_PORT;
            r_server0_ip   <= '0;
            r_server0_mac  <= '0;
            r_server1_ip   <= '0;
            r_server1_mac  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BALANCER_IP:  r_balancer_ip  <= i_cfg_data[31:0];
                CFG_BALANCER_MAC: r_balancer_mac <= i_cfg_data;
                CFG_SERVICE_PORT: r_service_port <= i_cfg_data[15:0];
                CFG_SERVER0_IP:   r_server0_ip   <= i_cfg_data[31:0];
                CFG_SERVER0_MAC:  r_server0_mac  <= i_cfg_data;
                CFG_SERVER1_IP:   r_server1_ip   <= i_cfg_data[31:0];
                CFG_SERVER1_MAC:  r_server1_mac  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_EMIT && w_out_free) r_out_valid <= 1'b1;
            else if (m_axis_tready)              r_out_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == SLOT_W'(SESSION_SLOTS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_in  <= w_hdr;
                        r_res <= w_echo;
                        if (!w_hdr.headers_ok) begin
                            r_state <= S_EMIT;
                        end else if (w_hdr.dport == r_service_port) begin
                            r_client <= 1'b1;
                            r_state  <= S_HASH;
                        end else if (w_hdr.sport == r_service_port) begin
                            r_client <= 1'b0;
                            r_slot   <= w_key_off[SLOT_W-1:0];
                            if (w_key_bad) begin
                                r_state <= S_EMIT;
                            end else begin
                                r_state <= S_READ;
                            end
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_HASH: begin
                    if (w_hash_done) begin
                        r_slot       <= w_hash_slot;
                        r_server_sel <= w_hash_sel;
                        r_state      <= S_READ;
                    end
                end
                S_READ:   r_state <= S_MODIFY;
                S_MODIFY: begin
                    r_res   <= w_mod;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.action;
    assign m_axis_tdata  = {7'd0, r_out.removed, r_out.dport, r_out.sport,
                            r_out.dst_ip, r_out.src_ip, r_out.src_mac, r_out.dst_mac};

endmodule

// File: tb/tb_top.sv
// self-checking testbench of the tcp session load balancer
module tb_top;
    import tslb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LIMIT_CYCLES = 3_000_000;
    localparam int unsigned N_CLIENTS    = 12;
    localparam int unsigned SETTLE       = 64;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic [199:0] s_axis_tdata = '0;
    logic [0:0]   s_axis_tuser = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [199:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index = '0;
    logic [47:0]  i_cfg_data = '0;

    tcp_session_load_balancer_top dut (.*);

    always #2 i_clk = ~i_clk;

    // shadow of the configuration registers
    logic [31:0] lb_ip;
    logic [47:0] lb_mac;
    logic [15:0] svc_port;
    logic [31:0] srv_ip [2];
    logic [47:0] srv_mac [2];

    // shadow of the session memory
    bit          sess_valid [SESSION_SLOTS];
    logic [31:0] sess_cli_ip [SESSION_SLOTS];
    logic [15:0] sess_cli_port [SESSION_SLOTS];
    logic [47:0] sess_cli_mac [SESSION_SLOTS];
    logic [31:0] sess_srv_ip [SESSION_SLOTS];
    logic [47:0] sess_srv_mac [SESSION_SLOTS];
    logic [1:0]  sess_closed [SESSION_SLOTS];

    t_result     verdicts_due [$];
    int unsigned fails, n_sent, n_tx, n_drop, n_pass, n_removed, n_cfg;
    int unsigned burst_left;
    int unsigned cycles;

    // client pool for the session sequences
    logic [31:0] cli_ip [N_CLIENTS];
    logic [15:0] cli_port [N_CLIENTS];
    logic [47:0] cli_mac [N_CLIENTS];

    function automatic logic [31:0] rotl17(input logic [31:0] v);
        return {v[14:0], v[31:15]};
    endfunction

    // xxh32 of ip bytes, port little-endian and two zero bytes, seed 0
    function automatic logic [31:0] client_digest(input logic [31:0] ip,
                                                  input logic [15:0] port);
        logic [31:0] h;
        h = XP5 + 32'd8;
        h = h + {ip[7:0], ip[15:8], ip[23:16], ip[31:24]} * XP3;
        h = rotl17(h) * XP4;
        h = h + {16'd0, port} * XP3;
        h = rotl17(h) * XP4;
        h = h ^ (h >> 15);
        h = h * XP2;
        h = h ^ (h >> 13);
        h = h * XP3;
        h = h ^ (h >> 16);
        return h;
    endfunction

    function automatic int unsigned slot_of(input logic [31:0] ip, input logic [15:0] port);
        return client_digest(ip, port) % SESSION_SLOTS;
    endfunction

    // rst deletes, fin closes an open side, ack on a closed side deletes once both closed
    function automatic logic close_side(input int unsigned s, input logic [1:0] side,
                                        input t_header hd);
        if (hd.rst) begin
            sess_valid[s] = 0;
            return 1'b1;
        end
        if ((sess_closed[s] & side) == 2'b00) begin
            if (hd.fin) sess_closed[s] = sess_closed[s] | side;
        end else if (hd.ack && sess_closed[s] == 2'b11) begin
            sess_valid[s] = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_result balance(input t_header hd);
        t_result     r;
        logic [31:0] h;
        int unsigned s, key;
        r.action   = ACT_PASS;
        r.dst_mac  = hd.dst_mac;
        r.src_mac  = hd.src_mac;
        r.src_ip   = hd.src_ip;
        r.dst_ip   = hd.dst_ip;
        r.sport    = hd.sport;
        r.dport    = hd.dport;
        r.removed  = 1'b0;
        if (!hd.headers_ok) return r;
        if (hd.dport == svc_port) begin
            h = client_digest(hd.src_ip, hd.sport);
            s = h % SESSION_SLOTS;
            if (hd.syn) begin
                if (sess_valid[s]) begin
                    r.action = ACT_DROP;
                    return r;
                end
                sess_valid[s]    = 1;
                sess_cli_ip[s]   = hd.src_ip;
                sess_cli_port[s] = hd.sport;
                sess_cli_mac[s]  = hd.src_mac;
                sess_srv_ip[s]   = srv_ip[h[0]];
                sess_srv_mac[s]  = srv_mac[h[0]];
                sess_closed[s]   = 2'b00;
            end
            if (!sess_valid[s]) begin
                r.action = ACT_DROP;
                return r;
            end
            r.action   = ACT_TX;
            r.dst_mac  = sess_srv_mac[s];
            r.src_mac  = lb_mac;
            r.src_ip   = lb_ip;
            r.dst_ip   = sess_srv_ip[s];
            r.sport    = 16'(((s + SLOT_PORT_BASE) & 'hFF) << 8) |
                         16'(((s + SLOT_PORT_BASE) >> 8) & 'hFF);
            r.removed  = close_side(s, SIDE_CLIENT, hd);
            return r;
        end
        if (hd.sport == svc_port) begin
            key = {hd.dport[7:0], hd.dport[15:8]};
            if (key < SLOT_PORT_BASE || key - SLOT_PORT_BASE >= SESSION_SLOTS) begin
                r.action = ACT_DROP;
                return r;
            end
            s = key - SLOT_PORT_BASE;
            if (!sess_valid[s]) begin
                r.action = ACT_DROP;
                return r;
            end
            r.action   = ACT_TX;
            r.dst_mac  = sess_cli_mac[s];
            r.src_mac  = lb_mac;
            r.src_ip   = lb_ip;
            r.dst_ip   = sess_cli_ip[s];
            r.dport    = sess_cli_port[s];
            r.removed  = close_side(s, SIDE_SERVER, hd);
        end
        return r;
    endfunction

    // sender: bursts of random length with random gaps; valid stays up across a burst
    task automatic send_header(input t_header hd);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= hd.headers_ok;
        s_axis_tdata  <= {4'd0, hd.rst, hd.ack, hd.fin, hd.syn, hd.dport, hd.sport,
                          hd.dst_ip, hd.src_ip, hd.dst_mac, hd.src_mac};
        forever begin
            @(negedge i_clk);
            if (s_axis_tready) break;
        end
        @(posedge i_clk);
        verdicts_due.push_back(balance(hd));
        n_sent++;
    endtask

    // pressure point: hold the sender until every request has its verdict
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        wait (verdicts_due.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        forever begin
            @(negedge i_clk);
            if (o_cfg_ready) break;
        end
        @(posedge i_clk);
        n_cfg++;
        case (idx)
            CFG_BALANCER_IP:  lb_ip = val[31:0];
            CFG_BALANCER_MAC: lb_mac = val;
            CFG_SERVICE_PORT: svc_port = val[15:0];
            CFG_SERVER0_IP:   srv_ip[0] = val[31:0];
            CFG_SERVER0_MAC:  srv_mac[0] = val;
            CFG_SERVER1_IP:   srv_ip[1] = val[31:0];
            CFG_SERVER1_MAC:  srv_mac[1] = val;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [31:0] lip, input logic [47:0] lmac,
                             input logic [15:0] sp, input logic [31:0] ip0,
                             input logic [47:0] mac0, input logic [31:0] ip1,
                             input logic [47:0] mac1);
        drain();
        write_reg(CFG_BALANCER_IP, {16'd0, lip});
        write_reg(CFG_BALANCER_MAC, lmac);
        write_reg(CFG_SERVICE_PORT, {32'd0, sp});
        write_reg(CFG_SERVER0_IP, {16'd0, ip0});
        write_reg(CFG_SERVER0_MAC, mac0);
        write_reg(CFG_SERVER1_IP, {16'd0, ip1});
        write_reg(CFG_SERVER1_MAC, mac1);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_header noise_header();
        t_header hd;
        hd.headers_ok = ($urandom_range(0, 4) != 0);
        hd.src_mac  = 48'({$urandom, $urandom});
        hd.dst_mac  = 48'({$urandom, $urandom});
        hd.src_ip   = $urandom;
        hd.dst_ip   = $urandom;
        hd.sport    = 16'($urandom);
        hd.dport    = 16'($urandom);
        {hd.syn, hd.fin, hd.ack, hd.rst} = 4'($urandom);
        return hd;
    endfunction

    // client request from pool member c with the given flags
    function automatic t_header from_client(input int unsigned c, input logic [3:0] flags);
        t_header hd;
        hd = noise_header();
        hd.headers_ok = 1'b1;
        hd.src_ip   = cli_ip[c];
        hd.sport    = cli_port[c];
        hd.src_mac  = cli_mac[c];
        hd.dport    = svc_port;
        {hd.syn, hd.fin, hd.ack, hd.rst} = flags;
        return hd;
    endfunction

    // server reply aimed at the slot of pool member c
    function automatic t_header from_server(input int unsigned c, input logic [3:0] flags);
        t_header     hd;
        int unsigned key;
        hd = noise_header();
        key = slot_of(cli_ip[c], cli_port[c]) + SLOT_PORT_BASE;
        hd.headers_ok = 1'b1;
        hd.sport = svc_port;
        hd.dport = {key[7:0], key[15:8]};
        {hd.syn, hd.fin, hd.ack, hd.rst} = flags;
        return hd;
    endfunction

    // flag sets, msb first: syn fin ack rst
    localparam logic [3:0] F_SYN = 4'b1000;
    localparam logic [3:0] F_FIN = 4'b0100;
    localparam logic [3:0] F_ACK = 4'b0010;
    localparam logic [3:0] F_RST = 4'b0001;

    task automatic test_special_cases();
        t_header hd;
        hd = noise_header();
        hd.headers_ok = 1'b0;
        hd.dport = svc_port;
        hd.syn = 1'b1;
        send_header(hd);                                        // incomplete headers
        hd = '1;
        send_header(hd);                                        // all ones, no service port
        hd = '0;
        hd.headers_ok = 1'b1;
        send_header(hd);                                        // all zeros
        send_header(from_client(0, F_ACK));                     // client on a free slot
        send_header(from_server(0, F_ACK));                     // server on a free slot
        send_header(from_client(0, F_SYN));                     // opens the session
        send_header(from_client(0, F_SYN));                     // syn on a taken slot
        send_header(from_server(0, F_SYN | F_ACK));
        send_header(from_client(0, F_ACK));
        send_header(from_client(0, F_FIN | F_ACK));             // client side closes
        send_header(from_client(0, F_ACK));                     // only one side closed
        send_header(from_server(0, F_FIN));                     // server side closes
        send_header(from_server(0, F_ACK));                     // ack after both closed
        send_header(from_client(0, F_ACK));                     // gone by now
        send_header(from_client(1, F_SYN | F_FIN));             // syn and fin together
        send_header(from_server(1, F_RST));                     // reset from the server
        send_header(from_client(2, F_SYN | F_RST));             // opened and reset at once
        hd = from_server(3, F_ACK);
        hd.dport = 16'h0000;                                    // reply port below the slots
        send_header(hd);
        hd.dport = 16'hFFFF;                                    // reply port above the slots
        send_header(hd);
        hd = from_client(3, F_SYN);
        hd.sport = svc_port;                                    // both ports are the service port
        send_header(hd);
        send_header(from_client(4, F_SYN));
        drain();
    endtask

    // mostly well-formed session traffic from the pool, some noise
    task automatic test_session_traffic(input int unsigned count);
        int unsigned c, pick;
        logic [3:0]  flags;
        repeat (count) begin
            c = $urandom_range(0, N_CLIENTS - 1);
            pick = $urandom_range(0, 99);
            flags = ($urandom_range(0, 9) == 0) ? 4'($urandom) : F_ACK;
            if (pick < 15)      send_header(noise_header());
            else if (pick < 30) send_header(from_client(c, F_SYN | (4'($urandom) & F_ACK)));
            else if (pick < 50) send_header(from_client(c, flags));
            else if (pick < 70) send_header(from_server(c, flags));
            else if (pick < 78) send_header(from_client(c, F_FIN | F_ACK));
            else if (pick < 86) send_header(from_server(c, F_FIN | F_ACK));
            else if (pick < 95) send_header(from_client(c, F_ACK));
            else if (pick < 98) send_header(from_server(c, F_RST));
            else                send_header(from_client(c, F_RST));
        end
    endtask

    task automatic test_register_settings();
        write_all('1, '1, 16'hFFFF, '1, '1, '0, '0);
        test_session_traffic(60);
        write_all('0, '0, 16'h0000, '0, '0, '1, '1);
        test_session_traffic(60);
        write_all($urandom, 48'({$urandom, $urandom}), 16'd443, $urandom,
                  48'({$urandom, $urandom}), $urandom, 48'({$urandom, $urandom}));
        test_session_traffic(60);
        write_all(RST_BALANCER_IP, RST_BALANCER_MAC, RST_SERVICE_PORT,
                  32'hC0A8_0001, 48'h0200_0000_0001, 32'hC0A8_0002, 48'h0200_0000_0002);
    endtask

    // receiver stall pattern: modes change in turn with the cycle counter
    always @(posedge i_clk) begin
        case (cycles[9:8])
            2'd0: m_axis_tready <= 1'b1;
            2'd1: m_axis_tready <= ($urandom_range(0, 1) == 0);
            2'd2: m_axis_tready <= (cycles[4:0] < 5'd6);
            default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t ns: %s expected %h actual %h", $time, name, exp_v, act_v);
            fails++;
        end
    endtask

    // verdict checker: a transfer at the coming edge is visible at the negedge before it
    always @(negedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (verdicts_due.size() == 0) begin
                $display("%0t ns: verdict with none expected, action %0d", $time, m_axis_tuser);
                fails++;
            end else begin
                exp_r = verdicts_due.pop_front();
                check_field("action", exp_r.action, m_axis_tuser);
                check_field("out_dst_mac", exp_r.dst_mac, m_axis_tdata[47:0]);
                check_field("out_src_mac", exp_r.src_mac, m_axis_tdata[95:48]);
                check_field("out_src_ip", exp_r.src_ip, m_axis_tdata[127:96]);
                check_field("out_dst_ip", exp_r.dst_ip, m_axis_tdata[159:128]);
                check_field("out_src_port", exp_r.sport, m_axis_tdata[175:160]);
                check_field("out_dst_port", exp_r.dport, m_axis_tdata[191:176]);
                check_field("session_removed", exp_r.removed, m_axis_tdata[192]);
                case (exp_r.action)
                    ACT_TX:   n_tx++;
                    ACT_DROP: n_drop++;
                    default:  n_pass++;
                endcase
                if (exp_r.removed) n_removed++;
            end
        end
    end

    // watchdog, sized for the slot clearing pass and slow client requests under stalls
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout with %0d verdicts outstanding", verdicts_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        fails = 0;
        n_sent = 0;
        n_tx = 0;
        n_drop = 0;
        n_pass = 0;
        n_removed = 0;
        n_cfg = 0;
        burst_left = 0;
        lb_ip = RST_BALANCER_IP;
        lb_mac = RST_BALANCER_MAC;
        svc_port = RST_SERVICE_PORT;
        srv_ip[0] = '0;
        srv_ip[1] = '0;
        srv_mac[0] = '0;
        srv_mac[1] = '0;
        foreach (cli_ip[i]) begin
            cli_ip[i] = $urandom;
            cli_port[i] = 16'($urandom_range(1024, 65000));
            cli_mac[i] = 48'({$urandom, $urandom});
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_special_cases();
        test_register_settings();
        test_session_traffic(250);
        drain();
        test_session_traffic(300);
        drain();

        $display("%0d headers, %0d register writes: %0d forwarded, %0d dropped, %0d passed",
                 n_sent, n_cfg, n_tx, n_drop, n_pass);
        $display("%0d sessions removed, %0d field mismatches", n_removed, fails);
        if (fails == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/tslb_pkg.sv
sv/tslb_hash.sv
sv/tcp_session_load_balancer_top.sv
tb/tb_top.sv
